// File: sv/bfi_pkg.sv
// Package: shared types, codes and the instruction decoder of the interpreter core.
package bfi_pkg;

  localparam int PROG_ADDR_W = 12;
  localparam int STEP_W      = 32;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_RIGHT = 8'h3E;
  localparam logic [7:0] CH_LEFT  = 8'h3C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h5B;
  localparam logic [7:0] CH_CLOSE = 8'h5D;

  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_RESUME  = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_OUT       = 3'd1,
    ST_NEED_IN   = 3'd2,
    ST_HALT      = 3'd3,
    ST_LIMIT     = 3'd4,
    ST_UNMATCHED = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    INS_END,
    INS_RIGHT,
    INS_LEFT,
    INS_PLUS,
    INS_MINUS,
    INS_DOT,
    INS_COMMA,
    INS_OPEN,
    INS_CLOSE,
    INS_OTHER
  } instr_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_LOAD,
    S_FETCH,
    S_EXEC,
    S_SCANF_RD,
    S_SCANF_EV,
    S_SCANB_RD,
    S_SCANB_EV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    ld_sub;
    logic    ld_write;
    logic    clr_start;
    logic    clr_step;
    logic    clr_prog;
    logic    restart;
    logic    in_write;
    logic    step_clear;
    logic    rd_prog;
    logic    rd_prev;
    logic    rd_tape;
    logic    ip_inc;
    logic    step_inc;
    logic    dp_inc;
    logic    dp_dec;
    logic    cell_inc;
    logic    cell_dec;
    logic    set_pending;
    logic    set_halted;
    logic    nest_clear;
    logic    nest_inc;
    logic    nest_dec;
    logic    out_load;
    status_t res_code;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       addr_big;
    logic       clr_last;
    logic       pending;
    logic       halted;
    logic       ip_end;
    logic       ip_zero;
    instr_t     instr;
    logic       cell_zero;
    logic       limit_hit;
    logic       nest_zero;
  } sts_t;

  function automatic instr_t decode_instr(input logic [7:0] c);
    instr_t r;
    case (c)
      CH_NUL:   r = INS_END;
      CH_RIGHT: r = INS_RIGHT;
      CH_LEFT:  r = INS_LEFT;
      CH_PLUS:  r = INS_PLUS;
      CH_MINUS: r = INS_MINUS;
      CH_DOT:   r = INS_DOT;
      CH_COMMA: r = INS_COMMA;
      CH_OPEN:  r = INS_OPEN;
      CH_CLOSE: r = INS_CLOSE;
      default:  r = INS_OTHER;
    endcase
    return r;
  endfunction

endpackage

// File: sv/brainfuck_interpreter_core.sv
// Top level: Brainfuck interpreter core, controller plus datapath.
//
//   channel | signals                                  | handshake
//   --------+------------------------------------------+-------------------------
//   in      | op, prog_addr, prog_byte, in_byte        | in_valid / in_stall
//   out     | status, out_byte                         | out_valid / out_stall
//   cfg     | cfg_data (step_limit)                    | cfg_valid / cfg_ready
//
// Load: the captured address is folded by subtracting PROG_DEPTH until it lies
// in the store, then the byte is written. Restart: one tape cell cleared per cycle.
// Resume: each instruction is fetched through the registered store read and then
// executed until a stop at an output, an input, the program end or the step
// limit; a bracket scan reads and evaluates each character it passes.
// After reset both memories are swept with in_stall high; cfg requests are
// taken throughout. A new request is taken while an earlier result is stalled
// in the output register.
module brainfuck_interpreter_core
  import bfi_pkg::*;
#(
  parameter int TAPE_DEPTH = 4096,
  parameter int PROG_DEPTH = 4096
)(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             op,
  input  logic [PROG_ADDR_W-1:0] prog_addr,
  input  logic [7:0]             prog_byte,
  input  logic [7:0]             in_byte,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [2:0]             status,
  output logic [7:0]             out_byte,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [STEP_W-1:0]      cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bfi_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bfi_dp #(
    .TAPE_DEPTH (TAPE_DEPTH),
    .PROG_DEPTH (PROG_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .op        (op),
    .prog_addr (prog_addr),
    .prog_byte (prog_byte),
    .in_byte   (in_byte),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .status    (status),
    .out_byte  (out_byte)
  );

endmodule

// File: sv/bfi_ctrl.sv
// Controller: sequencing state machine and output handshake of the interpreter core.
module bfi_ctrl
  import bfi_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t  state, state_next;
  status_t res_code, res_code_next;
  logic    clr_mode, clr_mode_next;
  logic    out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      res_code  <= ST_OK;
      clr_mode  <= 1'b1;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_code  <= res_code_next;
      clr_mode  <= clr_mode_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    state_next    = state;
    res_code_next = res_code;
    clr_mode_next = clr_mode;
    cmd           = '0;
    cmd.res_code  = res_code;
    cmd.clr_prog  = clr_mode;

    case (state)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) begin
          clr_mode_next = 1'b0;
          if (clr_mode) begin
            state_next = S_IDLE;
          end else begin
            res_code_next = ST_OK;
            state_next    = S_DONE;
          end
        end
      end

      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        case (sts.op)
          OP_LOAD: begin
            state_next = S_LOAD;
          end
          OP_RESTART: begin
            cmd.restart   = 1'b1;
            cmd.clr_start = 1'b1;
            state_next    = S_CLEAR;
          end
          OP_RESUME: begin
            cmd.in_write = sts.pending;
            if (sts.halted) begin
              res_code_next = ST_HALT;
              state_next    = S_DONE;
            end else begin
              cmd.step_clear = 1'b1;
              state_next     = S_FETCH;
            end
          end
          default: begin
            res_code_next = ST_OK;
            state_next    = S_DONE;
          end
        endcase
      end

      S_LOAD: begin
        if (sts.addr_big) begin
          cmd.ld_sub = 1'b1;
        end else begin
          cmd.ld_write  = 1'b1;
          res_code_next = ST_OK;
          state_next    = S_DONE;
        end
      end

      S_FETCH: begin
        cmd.rd_prog = 1'b1;
        cmd.rd_tape = 1'b1;
        state_next  = S_EXEC;
      end

      S_EXEC: begin
        if (sts.ip_end || sts.instr == INS_END) begin
          cmd.set_halted = 1'b1;
          res_code_next  = ST_HALT;
          state_next     = S_DONE;
        end else if (sts.limit_hit) begin
          res_code_next = ST_LIMIT;
          state_next    = S_DONE;
        end else begin
          cmd.step_inc = 1'b1;
          state_next   = S_FETCH;
          case (sts.instr)
            INS_RIGHT: begin
              cmd.ip_inc = 1'b1;
              cmd.dp_inc = 1'b1;
            end
            INS_LEFT: begin
              cmd.ip_inc = 1'b1;
              cmd.dp_dec = 1'b1;
            end
            INS_PLUS: begin
              cmd.ip_inc   = 1'b1;
              cmd.cell_inc = 1'b1;
            end
            INS_MINUS: begin
              cmd.ip_inc   = 1'b1;
              cmd.cell_dec = 1'b1;
            end
            INS_DOT: begin
              cmd.ip_inc    = 1'b1;
              res_code_next = ST_OUT;
              state_next    = S_DONE;
            end
            INS_COMMA: begin
              cmd.ip_inc      = 1'b1;
              cmd.set_pending = 1'b1;
              res_code_next   = ST_NEED_IN;
              state_next      = S_DONE;
            end
            INS_OPEN: begin
              cmd.ip_inc = 1'b1;
              if (sts.cell_zero) begin
                cmd.nest_clear = 1'b1;
                state_next     = S_SCANF_RD;
              end
            end
            INS_CLOSE: begin
              if (sts.cell_zero) begin
                cmd.ip_inc = 1'b1;
              end else begin
                cmd.nest_clear = 1'b1;
                state_next     = S_SCANB_RD;
              end
            end
            default: begin
              cmd.ip_inc = 1'b1;
            end
          endcase
        end
      end

      S_SCANF_RD: begin
        if (sts.ip_end) begin
          cmd.set_halted = 1'b1;
          res_code_next  = ST_UNMATCHED;
          state_next     = S_DONE;
        end else begin
          cmd.rd_prog = 1'b1;
          state_next  = S_SCANF_EV;
        end
      end

      S_SCANF_EV: begin
        state_next = S_SCANF_RD;
        if (sts.instr == INS_END) begin
          cmd.set_halted = 1'b1;
          res_code_next  = ST_UNMATCHED;
          state_next     = S_DONE;
        end else begin
          cmd.ip_inc = 1'b1;
          if (sts.instr == INS_CLOSE) begin
            if (sts.nest_zero) begin
              state_next = S_FETCH;
            end else begin
              cmd.nest_dec = 1'b1;
            end
          end else if (sts.instr == INS_OPEN) begin
            cmd.nest_inc = 1'b1;
          end
        end
      end

      S_SCANB_RD: begin
        if (sts.ip_zero) begin
          cmd.set_halted = 1'b1;
          res_code_next  = ST_UNMATCHED;
          state_next     = S_DONE;
        end else begin
          cmd.rd_prog = 1'b1;
          cmd.rd_prev = 1'b1;
          state_next  = S_SCANB_EV;
        end
      end

      S_SCANB_EV: begin
        state_next = S_SCANB_RD;
        if (sts.instr == INS_OPEN) begin
          if (sts.nest_zero) begin
            cmd.ip_inc = 1'b1;
            state_next = S_FETCH;
          end else begin
            cmd.nest_dec = 1'b1;
          end
        end else if (sts.instr == INS_CLOSE) begin
          cmd.nest_inc = 1'b1;
        end
      end

      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// File: sv/bfi_dp.sv
// Datapath: program store, tape, pointers, counters and result register of the core.
module bfi_dp
  import bfi_pkg::*;
#(
  parameter int TAPE_DEPTH = 4096,
  parameter int PROG_DEPTH = 4096
)(
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [1:0]             op,
  input  logic [PROG_ADDR_W-1:0] prog_addr,
  input  logic [7:0]             prog_byte,
  input  logic [7:0]             in_byte,
  input  logic                   cfg_valid,
  input  logic [STEP_W-1:0]      cfg_data,
  output logic [2:0]             status,
  output logic [7:0]             out_byte
);

  localparam int PAW  = $clog2(PROG_DEPTH);
  localparam int IPW  = $clog2(PROG_DEPTH + 1);
  localparam int TAW  = $clog2(TAPE_DEPTH);
  localparam int LW   = (PAW > PROG_ADDR_W) ? PAW : PROG_ADDR_W;
  localparam int MAXD = (TAPE_DEPTH > PROG_DEPTH) ? TAPE_DEPTH : PROG_DEPTH;
  localparam int CW   = $clog2(MAXD);

  logic [7:0] prog_mem [PROG_DEPTH];
  logic [7:0] tape_mem [TAPE_DEPTH];

  logic [IPW-1:0]    ip;
  logic [TAW-1:0]    dp;
  logic [IPW-1:0]    nest;
  logic              pending;
  logic              halted;
  logic [STEP_W-1:0] step_count;
  logic [STEP_W-1:0] step_limit;
  logic [CW-1:0]     clr_ctr;

  logic [1:0]        op_q;
  logic [LW-1:0]     ld_addr;
  logic [7:0]        ld_byte;
  logic [7:0]        in_q;
  logic [7:0]        pdata;
  logic [7:0]        tdata;

  logic              ip_end;
  logic [IPW-1:0]    ip_m1;
  logic              clr_in_prog;
  logic              clr_in_tape;

  logic              prog_we;
  logic [PAW-1:0]    prog_wa;
  logic [7:0]        prog_wd;
  logic              prog_re;
  logic [PAW-1:0]    prog_ra;

  logic              tape_we;
  logic [TAW-1:0]    tape_wa;
  logic [7:0]        tape_wd;

  assign ip_end      = (ip >= IPW'(PROG_DEPTH));
  assign ip_m1       = ip - 1'b1;
  assign clr_in_prog = ({1'b0, clr_ctr} < (CW + 1)'(PROG_DEPTH));
  assign clr_in_tape = ({1'b0, clr_ctr} < (CW + 1)'(TAPE_DEPTH));

  always_comb begin
    prog_we = cmd.ld_write || (cmd.clr_step && cmd.clr_prog && clr_in_prog);
    if (cmd.ld_write) begin
      prog_wa = ld_addr[PAW-1:0];
      prog_wd = ld_byte;
    end else begin
      prog_wa = clr_ctr[PAW-1:0];
      prog_wd = '0;
    end
    prog_re = cmd.rd_prog && (cmd.rd_prev || !ip_end);
    prog_ra = cmd.rd_prev ? ip_m1[PAW-1:0] : ip[PAW-1:0];

    tape_we = 1'b1;
    tape_wa = dp;
    if (cmd.clr_step) begin
      tape_we = clr_in_tape;
      tape_wa = clr_ctr[TAW-1:0];
      tape_wd = '0;
    end else if (cmd.in_write) begin
      tape_wd = in_q;
    end else if (cmd.cell_inc) begin
      tape_wd = tdata + 8'd1;
    end else if (cmd.cell_dec) begin
      tape_wd = tdata - 8'd1;
    end else begin
      tape_we = 1'b0;
      tape_wd = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (prog_we) begin
      prog_mem[prog_wa] <= prog_wd;
    end
    if (prog_re) begin
      pdata <= prog_mem[prog_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (tape_we) begin
      tape_mem[tape_wa] <= tape_wd;
    end
    if (cmd.rd_tape) begin
      tdata <= tape_mem[dp];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ip         <= '0;
      dp         <= '0;
      nest       <= '0;
      pending    <= 1'b0;
      halted     <= 1'b0;
      step_count <= '0;
      step_limit <= '0;
      clr_ctr    <= '0;
    end else begin
      if (cfg_valid) begin
        step_limit <= cfg_data;
      end

      if (cmd.clr_start) begin
        clr_ctr <= '0;
      end else if (cmd.clr_step) begin
        clr_ctr <= clr_ctr + 1'b1;
      end

      if (cmd.restart) begin
        ip         <= '0;
        dp         <= '0;
        nest       <= '0;
        pending    <= 1'b0;
        halted     <= 1'b0;
        step_count <= '0;
      end else begin
        if (cmd.ip_inc) begin
          ip <= ip + 1'b1;
        end else if (cmd.rd_prev) begin
          ip <= ip_m1;
        end

        if (cmd.dp_inc) begin
          dp <= (dp == TAW'(TAPE_DEPTH - 1)) ? '0 : dp + 1'b1;
        end else if (cmd.dp_dec) begin
          dp <= (dp == '0) ? TAW'(TAPE_DEPTH - 1) : dp - 1'b1;
        end

        if (cmd.nest_clear) begin
          nest <= '0;
        end else if (cmd.nest_inc) begin
          nest <= nest + 1'b1;
        end else if (cmd.nest_dec) begin
          nest <= nest - 1'b1;
        end

        if (cmd.set_pending) begin
          pending <= 1'b1;
        end else if (cmd.in_write) begin
          pending <= 1'b0;
        end

        if (cmd.set_halted) begin
          halted <= 1'b1;
        end

        if (cmd.step_clear) begin
          step_count <= '0;
        end else if (cmd.step_inc) begin
          step_count <= step_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q    <= op;
      ld_addr <= LW'(prog_addr);
      ld_byte <= prog_byte;
      in_q    <= in_byte;
    end else if (cmd.ld_sub) begin
      ld_addr <= ld_addr - LW'(PROG_DEPTH);
    end

    if (cmd.out_load) begin
      status   <= cmd.res_code;
      out_byte <= (cmd.res_code == ST_OUT) ? tdata : 8'd0;
    end
  end

  always_comb begin
    sts.op        = op_q;
    sts.addr_big  = ({1'b0, ld_addr} >= (LW + 1)'(PROG_DEPTH));
    sts.clr_last  = (clr_ctr == CW'(MAXD - 1));
    sts.pending   = pending;
    sts.halted    = halted;
    sts.ip_end    = ip_end;
    sts.ip_zero   = (ip == '0);
    sts.instr     = decode_instr(pdata);
    sts.cell_zero = (tdata == 8'd0);
    sts.limit_hit = (step_limit != '0) ? (step_count >= step_limit)
                                       : (step_count == '1);
    sts.nest_zero = (nest == '0);
  end

endmodule
